[rtl/fdr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_pkg
// Types, constants and step functions for the dielectric Fresnel pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

    localparam int COMPONENT_FRAC_BITS = 14;
    localparam int RESULT_FRAC_BITS    = 16;
    localparam int WORK_FRAC           = 30;
    localparam int ETA_FRAC            = 12;
    localparam int COMP_W              = 16;
    localparam int IOR_W               = 14;
    localparam int RES_W               = 17;

    localparam int CPROD_W   = 2 * COMP_W;
    localparam int DOT_W     = CPROD_W + 2;
    localparam int MAG_W     = DOT_W - 1;
    localparam int COS_SHIFT = WORK_FRAC - 2 * COMPONENT_FRAC_BITS;
    localparam int COS_W     = WORK_FRAC + 1;
    localparam int SQR_W     = 2 * COS_W;
    localparam int RAD_W     = 2 * WORK_FRAC + 1;
    localparam int SQ_STEPS  = (RAD_W + 1) / 2;
    localparam int RADP_W    = 2 * SQ_STEPS;
    localparam int SQ_REM_W  = COS_W + 3;
    localparam int SIN_T_W   = WORK_FRAC;
    localparam int PROD_W    = IOR_W + COS_W;
    localparam int DR_W      = PROD_W - WORK_FRAC;
    localparam int CF_W      = PROD_W - ETA_FRAC;
    localparam int DEN_W     = CF_W + 1;
    localparam int CQ_W      = WORK_FRAC + 1;
    localparam int KR_W      = 2 * CQ_W + 1;
    localparam int KR_SHIFT  = 2 * WORK_FRAC - RESULT_FRAC_BITS + 1;

    localparam logic [IOR_W-1:0] ETA_ONE = IOR_W'(1) << ETA_FRAC;
    localparam logic [COS_W-1:0] ONE_COS = COS_W'(1) << WORK_FRAC;
    localparam logic [RES_W-1:0] ONE_RES = RES_W'(1) << RESULT_FRAC_BITS;

    typedef struct packed {
        logic signed [COMP_W-1:0] wi_x;
        logic signed [COMP_W-1:0] wi_y;
        logic signed [COMP_W-1:0] wi_z;
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
        logic        [IOR_W-1:0]  ior;
    } item_t;

    typedef struct packed {
        logic [COS_W-1:0] cos_i;
        logic [IOR_W-1:0] eta_i;
        logic [IOR_W-1:0] eta_t;
        logic             tir;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        side_t            side;
    } sqrt_in_t;

    typedef struct packed {
        logic [COS_W-1:0] root;
        side_t            side;
    } sqrt_out_t;

    typedef struct packed {
        logic [RES_W-1:0] reflectance;
        logic             total_reflection;
    } result_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [COS_W-1:0]    root;
    } sq_acc_t;

    typedef struct packed {
        logic [DR_W-1:0]      rem;
        logic [WORK_FRAC-1:0] low;
        logic [SIN_T_W-1:0]   q;
    } sdiv_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [CQ_W-1:0]  q;
        logic             lb;
        logic             zero;
    } cdiv_t;

    // one digit of a restoring square root
    function automatic sq_acc_t sqrt_step(sq_acc_t a, logic [1:0] pair);
        logic [SQ_REM_W-1:0] sh;
        logic [SQ_REM_W-1:0] trial;
        sq_acc_t             r;
        sh    = {a.rem[SQ_REM_W-3:0], pair};
        trial = {1'b0, a.root, 2'b01};
        if (sh >= trial)
        begin
            r.rem  = sh - trial;
            r.root = {a.root[COS_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = sh;
            r.root = {a.root[COS_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of eta_i * sin_i / eta_t
    function automatic sdiv_t sdiv_step(sdiv_t a, logic [IOR_W-1:0] d);
        logic [DR_W:0] sh;
        logic [DR_W:0] dd;
        sdiv_t         r;
        sh    = {a.rem, a.low[WORK_FRAC-1]};
        dd    = (DR_W + 1)'(d);
        r.low = a.low << 1;
        if (sh >= dd)
        begin
            r.rem = DR_W'(sh - dd);
            r.q   = {a.q[SIN_T_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[DR_W-1:0];
            r.q   = {a.q[SIN_T_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of num * 2^30 / den
    function automatic cdiv_t cdiv_step(cdiv_t a);
        logic [DEN_W:0] sh;
        logic [DEN_W:0] dd;
        cdiv_t          r;
        r  = a;
        sh = {a.rem, a.lb};
        dd = {1'b0, a.den};
        if (sh >= dd)
        begin
            r.rem = DEN_W'(sh - dd);
            r.q   = {a.q[CQ_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[DEN_W-1:0];
            r.q   = {a.q[CQ_W-2:0], 1'b0};
        end
        r.lb = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/fdr_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_in_if
// Input channel: incident direction, normal and refractive index.
// ----------------------------------------------------------------------------
interface fdr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wi_x;
    logic signed [15:0] wi_y;
    logic signed [15:0] wi_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [13:0] ior;

    modport source (output valid, wi_x, wi_y, wi_z, normal_x, normal_y, normal_z, ior,
                    input ready);
    modport sink   (input valid, wi_x, wi_y, wi_z, normal_x, normal_y, normal_z, ior,
                    output ready);
endinterface
`default_nettype wire

[rtl/fdr_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_out_if
// Output channel: reflectance and total reflection flag.
// ----------------------------------------------------------------------------
interface fdr_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] reflectance;
    logic        total_reflection;

    modport source (output valid, reflectance, total_reflection, input ready);
    modport sink   (input valid, reflectance, total_reflection, output ready);
endinterface
`default_nettype wire

[rtl/fdr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_front
// Dot product, cosine clamp, index swap and 1 - cos^2 radicand (4 stages).
// ----------------------------------------------------------------------------
module fdr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  fdr_pkg::item_t    in_data,
    output logic              out_valid,
    output fdr_pkg::sqrt_in_t out_data
);
    import fdr_pkg::*;

    logic [3:0] v_reg;

    logic signed [CPROD_W-1:0] p0_reg;
    logic signed [CPROD_W-1:0] p1_reg;
    logic signed [CPROD_W-1:0] p2_reg;
    logic [IOR_W-1:0]          ior_reg;

    side_t side2_reg;
    side_t side3_reg;
    side_t side4_reg;
    logic [SQR_W-1:0] sq_reg;
    logic [RAD_W-1:0] rad_reg;

    logic signed [DOT_W-1:0] dot;
    logic [MAG_W-1:0]        mag;
    side_t                   side2_next;

    always_comb
    begin
        dot = DOT_W'(p0_reg) + DOT_W'(p1_reg) + DOT_W'(p2_reg);
        mag = dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
        if (mag >= (MAG_W'(1) << (2 * COMPONENT_FRAC_BITS)))
            side2_next.cos_i = ONE_COS;
        else
            side2_next.cos_i = COS_W'(mag) << COS_SHIFT;
        if (!dot[DOT_W-1] && (dot != '0))
        begin
            side2_next.eta_i = ior_reg;
            side2_next.eta_t = ETA_ONE;
        end
        else
        begin
            side2_next.eta_i = ETA_ONE;
            side2_next.eta_t = ior_reg;
        end
        side2_next.tir = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg    <= in_data.wi_x * in_data.normal_x;
            p1_reg    <= in_data.wi_y * in_data.normal_y;
            p2_reg    <= in_data.wi_z * in_data.normal_z;
            ior_reg   <= in_data.ior;
            side2_reg <= side2_next;
            sq_reg    <= SQR_W'(side2_reg.cos_i) * SQR_W'(side2_reg.cos_i);
            side3_reg <= side2_reg;
            rad_reg   <= RAD_W'((SQR_W'(1) << (2 * WORK_FRAC)) - sq_reg);
            side4_reg <= side3_reg;
        end
    end

    assign out_valid     = v_reg[3];
    assign out_data.rad  = rad_reg;
    assign out_data.side = side4_reg;

endmodule
`default_nettype wire

[rtl/fdr_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fdr_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  fdr_pkg::sqrt_in_t  in_data,
    output logic               out_valid,
    output fdr_pkg::sqrt_out_t out_data
);
    import fdr_pkg::*;

    logic              v_reg    [SQ_STEPS];
    logic [RADP_W-1:0] rad_reg  [SQ_STEPS];
    sq_acc_t           acc_reg  [SQ_STEPS];
    side_t             side_reg [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_stage
        logic              v_prev;
        logic [RADP_W-1:0] rad_prev;
        sq_acc_t           acc_prev;
        side_t             side_prev;

        if (g == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = RADP_W'(in_data.rad);
            assign acc_prev  = '0;
            assign side_prev = in_data.side;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[g-1];
            assign rad_prev  = rad_reg[g-1];
            assign acc_prev  = acc_reg[g-1];
            assign side_prev = side_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (adv)
                v_reg[g] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[g]  <= rad_prev << 2;
                acc_reg[g]  <= sqrt_step(acc_prev, rad_prev[RADP_W-1 -: 2]);
                side_reg[g] <= side_prev;
            end
        end
    end

    assign out_valid     = v_reg[SQ_STEPS-1];
    assign out_data.root = acc_reg[SQ_STEPS-1].root;
    assign out_data.side = side_reg[SQ_STEPS-1];

endmodule
`default_nettype wire

[rtl/fdr_snell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_snell
// Total reflection test, transmitted sine by long division, 1 - sin_t^2.
// ----------------------------------------------------------------------------
module fdr_snell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  fdr_pkg::sqrt_out_t in_data,
    output logic               out_valid,
    output fdr_pkg::sqrt_in_t  out_data
);
    import fdr_pkg::*;

    logic             va_reg;
    logic             vb_reg;
    logic             vs_reg;
    logic             vr_reg;
    logic [PROD_W-1:0] p_reg;
    side_t            sidea_reg;
    side_t            sideb_reg;
    sdiv_t            divb_reg;

    logic  v_reg    [SIN_T_W];
    sdiv_t div_reg  [SIN_T_W];
    side_t side_reg [SIN_T_W];

    logic [2*SIN_T_W-1:0] sq_reg;
    side_t                sides_reg;
    logic [RAD_W-1:0]     rad_reg;
    side_t                sider_reg;

    side_t sideb_next;
    sdiv_t divb_next;

    always_comb
    begin
        sideb_next     = sidea_reg;
        sideb_next.tir = p_reg >= (PROD_W'(sidea_reg.eta_t) << WORK_FRAC);
        divb_next.rem  = p_reg[PROD_W-1 -: DR_W];
        divb_next.low  = p_reg[WORK_FRAC-1:0];
        divb_next.q    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vs_reg <= 1'b0;
            vr_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vs_reg <= v_reg[SIN_T_W-1];
            vr_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg     <= PROD_W'(in_data.side.eta_i) * PROD_W'(in_data.root);
            sidea_reg <= in_data.side;
            sideb_reg <= sideb_next;
            divb_reg  <= divb_next;
            sq_reg    <= (2 * SIN_T_W)'(div_reg[SIN_T_W-1].q)
                       * (2 * SIN_T_W)'(div_reg[SIN_T_W-1].q);
            sides_reg <= side_reg[SIN_T_W-1];
            rad_reg   <= (RAD_W'(1) << (2 * WORK_FRAC)) - RAD_W'(sq_reg);
            sider_reg <= sides_reg;
        end
    end

    for (genvar g = 0; g < SIN_T_W; g++)
    begin : g_stage
        logic  v_prev;
        sdiv_t div_prev;
        side_t side_prev;

        if (g == 0)
        begin : g_first
            assign v_prev    = vb_reg;
            assign div_prev  = divb_reg;
            assign side_prev = sideb_reg;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[g-1];
            assign div_prev  = div_reg[g-1];
            assign side_prev = side_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (adv)
                v_reg[g] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[g]  <= sdiv_step(div_prev, side_prev.eta_t);
                side_reg[g] <= side_prev;
            end
        end
    end

    assign out_valid     = vr_reg;
    assign out_data.rad  = rad_reg;
    assign out_data.side = sider_reg;

endmodule
`default_nettype wire

[rtl/fdr_coef.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_coef
// Rs and Rp by two long dividers, squares, mean and saturation; holds the
// output register.
// ----------------------------------------------------------------------------
module fdr_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  fdr_pkg::sqrt_out_t in_data,
    output logic               out_valid,
    output fdr_pkg::result_t   out_data
);
    import fdr_pkg::*;

    logic            va_reg;
    logic            vb_reg;
    logic            vq_reg;
    logic            vo_reg;
    logic [CF_W-1:0] as_reg;
    logic [CF_W-1:0] bs_reg;
    logic [CF_W-1:0] ap_reg;
    logic [CF_W-1:0] bp_reg;
    logic            tira_reg;
    logic            tirb_reg;
    cdiv_t           dsb_reg;
    cdiv_t           dpb_reg;

    logic  v_reg   [CQ_W];
    logic  tir_reg [CQ_W];
    cdiv_t ds_reg  [CQ_W];
    cdiv_t dp_reg  [CQ_W];

    logic [SQR_W-1:0] rs2_reg;
    logic [SQR_W-1:0] rp2_reg;
    logic             tirq_reg;
    result_t          res_reg;

    logic [PROD_W-1:0] ps_a;
    logic [PROD_W-1:0] ps_b;
    logic [PROD_W-1:0] pp_a;
    logic [PROD_W-1:0] pp_b;
    cdiv_t             dsb_next;
    cdiv_t             dpb_next;
    logic [COS_W-1:0]  rs;
    logic [COS_W-1:0]  rp;
    logic [KR_W-1:0]   sum;
    logic [KR_W-1:0]   kr;
    result_t           res_next;

    function automatic cdiv_t cdiv_init(logic [CF_W-1:0] a, logic [CF_W-1:0] b);
        logic [CF_W-1:0] num;
        cdiv_t           r;
        num    = (a >= b) ? (a - b) : (b - a);
        r.den  = DEN_W'(a) + DEN_W'(b);
        r.zero = (r.den == '0);
        r.rem  = DEN_W'(num >> 1);
        r.lb   = num[0];
        r.q    = '0;
        return r;
    endfunction

    always_comb
    begin
        ps_a     = PROD_W'(in_data.side.eta_t) * PROD_W'(in_data.side.cos_i);
        ps_b     = PROD_W'(in_data.side.eta_i) * PROD_W'(in_data.root);
        pp_a     = PROD_W'(in_data.side.eta_i) * PROD_W'(in_data.side.cos_i);
        pp_b     = PROD_W'(in_data.side.eta_t) * PROD_W'(in_data.root);
        dsb_next = cdiv_init(as_reg, bs_reg);
        dpb_next = cdiv_init(ap_reg, bp_reg);
        rs       = ds_reg[CQ_W-1].zero ? ONE_COS : ds_reg[CQ_W-1].q;
        rp       = dp_reg[CQ_W-1].zero ? ONE_COS : dp_reg[CQ_W-1].q;
        sum      = KR_W'(rs2_reg) + KR_W'(rp2_reg);
        kr       = sum >> KR_SHIFT;
        res_next.total_reflection = tirq_reg;
        if (tirq_reg || (kr > KR_W'(ONE_RES)))
            res_next.reflectance = ONE_RES;
        else
            res_next.reflectance = RES_W'(kr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vq_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vq_reg <= v_reg[CQ_W-1];
            vo_reg <= vq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            as_reg   <= ps_a[PROD_W-1:ETA_FRAC];
            bs_reg   <= ps_b[PROD_W-1:ETA_FRAC];
            ap_reg   <= pp_a[PROD_W-1:ETA_FRAC];
            bp_reg   <= pp_b[PROD_W-1:ETA_FRAC];
            tira_reg <= in_data.side.tir;
            dsb_reg  <= dsb_next;
            dpb_reg  <= dpb_next;
            tirb_reg <= tira_reg;
            rs2_reg  <= SQR_W'(rs) * SQR_W'(rs);
            rp2_reg  <= SQR_W'(rp) * SQR_W'(rp);
            tirq_reg <= tir_reg[CQ_W-1];
            res_reg  <= res_next;
        end
    end

    for (genvar g = 0; g < CQ_W; g++)
    begin : g_stage
        logic  v_prev;
        logic  tir_prev;
        cdiv_t ds_prev;
        cdiv_t dp_prev;

        if (g == 0)
        begin : g_first
            assign v_prev   = vb_reg;
            assign tir_prev = tirb_reg;
            assign ds_prev  = dsb_reg;
            assign dp_prev  = dpb_reg;
        end
        else
        begin : g_rest
            assign v_prev   = v_reg[g-1];
            assign tir_prev = tir_reg[g-1];
            assign ds_prev  = ds_reg[g-1];
            assign dp_prev  = dp_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (adv)
                v_reg[g] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tir_reg[g] <= tir_prev;
                ds_reg[g]  <= cdiv_step(ds_prev);
                dp_reg[g]  <= cdiv_step(dp_prev);
            end
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = res_reg;

endmodule
`default_nettype wire

[rtl/dielectric_fresnel_reflectance.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dielectric_fresnel_reflectance
// Unpolarized Fresnel reflectance of a dielectric interface, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  item     in   wi_x/y/z, normal_x/y/z (Q2.14), ior (Q2.12)
//  result   out  reflectance (Q1.16), total_reflection
//
//  One beat in per cycle while the output is not stalled, one result per beat.
//  The pipe runs front, two square roots of 31 stages, Snell divider, then
//  coefficient dividers and mean. All stages share one advance enable:
//  a held result freezes the whole pipe, nothing is dropped or repeated.
//  Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module dielectric_fresnel_reflectance (
    input  logic   clk,
    input  logic   rst_n,
    fdr_in_if.sink   item,
    fdr_out_if.source result
);
    import fdr_pkg::*;

    logic      adv;
    item_t     item_data;
    logic      fr_valid;
    sqrt_in_t  fr_data;
    logic      s1_valid;
    sqrt_out_t s1_data;
    logic      sn_valid;
    sqrt_in_t  sn_data;
    logic      s2_valid;
    sqrt_out_t s2_data;
    logic      co_valid;
    result_t   co_data;

    assign adv        = !co_valid || result.ready;
    assign item.ready = adv;

    assign item_data.wi_x     = item.wi_x;
    assign item_data.wi_y     = item.wi_y;
    assign item_data.wi_z     = item.wi_z;
    assign item_data.normal_x = item.normal_x;
    assign item_data.normal_y = item.normal_y;
    assign item_data.normal_z = item.normal_z;
    assign item_data.ior      = item.ior;

    fdr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item.valid),
        .in_data   (item_data),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    fdr_sqrt u_sin_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    fdr_snell u_snell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (sn_valid),
        .out_data  (sn_data)
    );

    fdr_sqrt u_cos_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sn_valid),
        .in_data   (sn_data),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    fdr_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .out_valid (co_valid),
        .out_data  (co_data)
    );

    assign result.valid            = co_valid;
    assign result.reflectance      = co_data.reflectance;
    assign result.total_reflection = co_data.total_reflection;

endmodule
`default_nettype wire

[dv/dielectric_fresnel_reflectance_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dielectric_fresnel_reflectance_test
// Streams incident/normal/index beats through the Fresnel pipeline and checks
// every result against an in-bench fixed-point reflectance calculation, with
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module dielectric_fresnel_reflectance_test;
    import fdr_pkg::*;

    localparam int  N_RANDOM   = 750;
    localparam int  LATENCY    = 135;
    localparam int  CYCLE_CAP  = 400000;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] ONE_Q12 = 64'd1 << 12;

    logic clk;
    logic rst_n;

    fdr_in_if  item ();
    fdr_out_if result ();

    dielectric_fresnel_reflectance u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    item_t   pending_beats[$];
    result_t expected_kr[$];
    int      errors;
    int      cycles;
    bit      stim_done;
    bit      calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] coef_ratio(logic [63:0] a, logic [63:0] b);
        logic [63:0] num;
        logic [63:0] den;
        num = (a >= b) ? a - b : b - a;
        den = a + b;
        if (den == 0)
            return ONE_Q30;
        return (num << 30) / den;
    endfunction

    function automatic result_t fresnel_kr(item_t it);
        logic signed [63:0] dot;
        logic [63:0] mag, cos_i, sin_i, eta_i, eta_t, sin_t, cos_t, rs, rp, kr;
        result_t r;
        dot = 64'(it.wi_x) * 64'(it.normal_x) + 64'(it.wi_y) * 64'(it.normal_y)
            + 64'(it.wi_z) * 64'(it.normal_z);
        mag   = (dot < 0) ? 64'(-dot) : 64'(dot);
        cos_i = mag << 2;
        if (cos_i > ONE_Q30)
            cos_i = ONE_Q30;
        if (dot > 0)
        begin
            eta_i = 64'(it.ior);
            eta_t = ONE_Q12;
        end
        else
        begin
            eta_i = ONE_Q12;
            eta_t = 64'(it.ior);
        end
        sin_i = int_sqrt((ONE_Q30 << 30) - cos_i * cos_i);
        if (eta_i * sin_i >= (eta_t << 30))
        begin
            r.reflectance      = ONE_RES;
            r.total_reflection = 1'b1;
            return r;
        end
        sin_t = (eta_i * sin_i) / eta_t;
        cos_t = int_sqrt((ONE_Q30 << 30) - sin_t * sin_t);
        rs = coef_ratio((eta_t * cos_i) >> 12, (eta_i * cos_t) >> 12);
        rp = coef_ratio((eta_i * cos_i) >> 12, (eta_t * cos_t) >> 12);
        kr = (rs * rs + rp * rp) >> 45;
        if (kr > 64'(ONE_RES))
            kr = 64'(ONE_RES);
        r.reflectance      = kr[RES_W-1:0];
        r.total_reflection = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h4000;
            3: return 16'hC000;
            4: return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_beat(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [13:0] ior);
        item_t it;
        it.wi_x = wx; it.wi_y = wy; it.wi_z = wz;
        it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
        it.ior = ior;
        pending_beats.push_back(it);
    endtask

    // unit vector from a random angle, mostly in a plane with the normal
    task automatic push_unit_pair();
        real th, s;
        logic [15:0] wx, wz, nx, nz;
        logic [13:0] ior;
        th = ($urandom_range(0, 10000) / 10000.0) * 6.2831853;
        s  = $urandom_range(0, 1) ? -1.0 : 1.0;
        wx = 16'($rtoi($sin(th) * 16384.0));
        wz = 16'($rtoi($cos(th) * 16384.0));
        nx = 16'sd0;
        nz = 16'($rtoi(s * 16384.0));
        ior = 14'($urandom_range(4096, 16383));
        if ($urandom_range(0, 3) == 0)
            ior = 14'($urandom_range(4096, 8192));
        push_beat(wx, 16'($urandom_range(0, 40)), wz, nx, 16'd0, nz, ior);
    endtask

    initial
    begin
        errors    = 0;
        stim_done = 1'b0;
        // directed: normal, grazing, oblique both ways, non-unit, index extremes
        push_beat(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 14'd6144);
        push_beat(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 14'd6144);
        push_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 14'd6144);
        push_beat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 14'd6144);
        push_beat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000, 16'h0000, 16'h4000, 14'd6144);
        push_beat(16'h2000, 16'h0000, 16'h376D, 16'h0000, 16'h0000, 16'h4000, 14'd6144);
        push_beat(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 14'd4096);
        push_beat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 14'd4096);
        push_beat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 14'd16383);
        push_beat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000, 16'h0000, 16'h4000, 14'd16383);
        push_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 14'd6144);
        push_beat(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 14'd6144);
        push_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 14'd16383);
        push_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'd6144);
        push_beat(16'h1234, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 14'd0);
        push_beat(16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 14'd0);
        push_beat(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 14'd8191);
        push_beat(16'h0000, 16'hC000, 16'h0001, 16'h0000, 16'h4000, 16'h0000, 14'd8192);
        push_beat(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 14'h3FFF);
        push_beat(16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 16'hCCCC, 16'h3333, 14'h2AAA);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 99) < 70)
                push_unit_pair();
            else
                push_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                          rand_comp(), rand_comp(),
                          $urandom_range(0, 19) == 0 ? 14'($urandom) :
                          14'($urandom_range(4096, 16383)));
        end
        stim_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid    <= 1'b0;
            item.wi_x     <= '0;
            item.wi_y     <= '0;
            item.wi_z     <= '0;
            item.normal_x <= '0;
            item.normal_y <= '0;
            item.normal_z <= '0;
            item.ior      <= '0;
        end
        else if (!item.valid || item.ready)
        begin
            if (item.valid)
                expected_kr.push_back(fresnel_kr(pending_beats.pop_front()));
            if (pending_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 9))
            begin
                item.valid    <= 1'b1;
                item.wi_x     <= pending_beats[0].wi_x;
                item.wi_y     <= pending_beats[0].wi_y;
                item.wi_z     <= pending_beats[0].wi_z;
                item.normal_x <= pending_beats[0].normal_x;
                item.normal_y <= pending_beats[0].normal_y;
                item.normal_z <= pending_beats[0].normal_z;
                item.ior      <= pending_beats[0].ior;
            end
            else
                item.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            cycles       <= 0;
            calm         <= 1'b0;
        end
        else
        begin
            cycles <= cycles + 1;
            calm   <= (cycles >= 200 && cycles < 600);
            if (result.valid && result.ready)
            begin
                if (expected_kr.size() == 0)
                    report_mismatch("unexpected beat", 64'(result.reflectance), 0);
                else
                begin
                    want = expected_kr.pop_front();
                    if (result.reflectance !== want.reflectance)
                        report_mismatch("reflectance", 64'(result.reflectance),
                                        64'(want.reflectance));
                    if (result.total_reflection !== want.total_reflection)
                        report_mismatch("total_reflection", 64'(result.total_reflection),
                                        64'(want.total_reflection));
                end
            end
            result.ready <= calm || $urandom_range(0, 99) >= 9;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (stim_done);
        while ((pending_beats.size() > 0 || item.valid || expected_kr.size() > 0)
               && cycles < CYCLE_CAP)
            @(posedge clk);
        if (cycles >= CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 20) @(posedge clk);
            if (errors == 0 && expected_kr.size() == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
